### src/reduced_precision_float_multiplier_top_defines.svh
// ----------------------------------------------------------------------------
// Reduced-precision float multiplier assertion macros
// Shared property wrappers for the checker of the multiplier ports.
// ----------------------------------------------------------------------------
`ifndef REDUCED_PRECISION_FLOAT_MULTIPLIER_TOP_DEFINES_SVH
`define REDUCED_PRECISION_FLOAT_MULTIPLIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPFM_ASSERT_SAME(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPFM_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rpfm_pkg.sv
// ----------------------------------------------------------------------------
// Reduced-precision float multiplier package
// Widths, register codes and shared types of the minifloat multiplier.
// ----------------------------------------------------------------------------
package rpfm_pkg;

	localparam int MAX_MANT_BITS = 15;
	localparam int MAX_EXP_BITS  = 8;
	localparam int FP32_BIAS     = 127;

	localparam int WORD_W    = 32;
	localparam int FP_EXP_W  = 8;
	localparam int FP_MANT_W = 23;
	localparam int SH_W      = $clog2(FP_MANT_W + 1);

	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam int MANT_W = MAX_MANT_BITS;
	localparam int SIG_W  = MANT_W + 1;
	localparam int PROD_W = 2 * SIG_W;
	localparam int NORM_W = PROD_W + 3;
	localparam int POS_W  = $clog2(NORM_W);
	localparam int IDX_W  = $clog2(PROD_W);

	localparam int EXP_W  = MAX_EXP_BITS;
	localparam int NEXP_W = FP_EXP_W + 2;
	localparam int ESUM_W = EXP_W + 3;

	localparam logic [CFG_W-1:0] EXP_BITS_RST  = CFG_W'(8);
	localparam logic [CFG_W-1:0] MANT_BITS_RST = CFG_W'(7);
	localparam logic [CFG_W-1:0] MIN_WIDTH     = CFG_W'(2);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXP_BITS  = 1'b0,
		REG_MANT_BITS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]  e_w;
		logic [CFG_W-1:0]  m_w;
		logic [EXP_W-1:0]  bias;
		logic [EXP_W-1:0]  emax;
		logic [MANT_W-1:0] mmask;
	} fmt_t;

	typedef struct packed {
		logic              sign;
		logic [EXP_W-1:0]  exp;
		logic [MANT_W-1:0] mant;
		logic              err;
	} narrow_t;

	function automatic fmt_t make_fmt(logic [CFG_W-1:0] exp_bits, logic [CFG_W-1:0] mant_bits);
		fmt_t            f;
		logic [EXP_W:0]  pw_e;
		logic [MANT_W:0] pw_m;
		if (exp_bits < MIN_WIDTH) begin
			f.e_w = MIN_WIDTH;
		end else if (exp_bits > CFG_W'(MAX_EXP_BITS)) begin
			f.e_w = CFG_W'(MAX_EXP_BITS);
		end else begin
			f.e_w = exp_bits;
		end
		if (mant_bits < MIN_WIDTH) begin
			f.m_w = MIN_WIDTH;
		end else if (mant_bits > CFG_W'(MAX_MANT_BITS)) begin
			f.m_w = CFG_W'(MAX_MANT_BITS);
		end else begin
			f.m_w = mant_bits;
		end
		pw_e    = (EXP_W + 1)'(1) << f.e_w;
		pw_m    = (MANT_W + 1)'(1) << f.m_w;
		f.emax  = EXP_W'(pw_e - 1'b1);
		f.bias  = EXP_W'((pw_e >> 1) - 1'b1);
		f.mmask = MANT_W'(pw_m - 1'b1);
		return f;
	endfunction

endpackage

### src/rpfm_narrow.sv
// ----------------------------------------------------------------------------
// Operand narrowing
// Turns an IEEE single pattern into the reduced format: rebiased and
// clamped exponent, truncated mantissa and a range flag.
// ----------------------------------------------------------------------------
module rpfm_narrow (
	input  logic [rpfm_pkg::WORD_W-1:0] operand,
	input  rpfm_pkg::fmt_t              fmt,
	output rpfm_pkg::narrow_t           res
);

	logic signed [rpfm_pkg::NEXP_W-1:0]  e_reb;
	logic signed [rpfm_pkg::NEXP_W-1:0]  emax_s;
	logic [rpfm_pkg::SH_W-1:0]           sh;
	logic [rpfm_pkg::FP_MANT_W-1:0]      mant_sh;

	assign emax_s  = $signed({2'b00, fmt.emax});
	assign e_reb   = $signed({2'b00, operand[30:23]})
	               - $signed(rpfm_pkg::NEXP_W'(rpfm_pkg::FP32_BIAS))
	               + $signed({2'b00, fmt.bias});
	assign sh      = rpfm_pkg::SH_W'(rpfm_pkg::FP_MANT_W) - rpfm_pkg::SH_W'(fmt.m_w);
	assign mant_sh = operand[rpfm_pkg::FP_MANT_W-1:0] >> sh;

	always_comb begin
		res.sign = operand[rpfm_pkg::WORD_W-1];
		res.mant = mant_sh[rpfm_pkg::MANT_W-1:0] & fmt.mmask;
		if (e_reb > emax_s) begin
			res.exp = fmt.emax;
			res.err = 1'b1;
		end else if (e_reb[rpfm_pkg::NEXP_W-1]) begin
			res.exp = '0;
			res.err = 1'b1;
		end else begin
			res.exp = e_reb[rpfm_pkg::EXP_W-1:0];
			res.err = 1'b0;
		end
	end

endmodule

### src/reduced_precision_float_multiplier_top.sv
// ----------------------------------------------------------------------------
// Reduced-precision float multiplier
// Multiplies two IEEE single patterns in a configurable minifloat format.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle unless stalled and returns
// its result through a five-stage pipeline: operand narrowing, significand
// multiply, normalization, rounding, and exponent clamp with repacking. A
// stall on the output holds the last stage and backs up only as far as the
// pipeline is full, so bubbles are squeezed out and the input keeps taking
// requests until every stage holds one. Register 0 sets the exponent width
// (2 to 8) and register 1 the stored mantissa width (2 to 15); values outside
// those ranges are saturated. Write them only while no request is in flight.
module reduced_precision_float_multiplier_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [rpfm_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [rpfm_pkg::CFG_W-1:0]          wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [rpfm_pkg::WORD_W-1:0]         operand_a,
	input  logic [rpfm_pkg::WORD_W-1:0]         operand_b,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rpfm_pkg::WORD_W-1:0]         product,
	output logic                                range_error
);

	logic [rpfm_pkg::CFG_W-1:0] exp_bits_q;
	logic [rpfm_pkg::CFG_W-1:0] mant_bits_q;
	rpfm_pkg::fmt_t             fmt;

	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	rpfm_pkg::narrow_t nar_a, nar_b;
	rpfm_pkg::narrow_t na_s1, nb_s1;

	logic [rpfm_pkg::SIG_W-1:0]          hidden, sig_a, sig_b;
	logic [rpfm_pkg::PROD_W-1:0]         prod_c;
	logic signed [rpfm_pkg::ESUM_W-1:0]  esum_c;
	logic [rpfm_pkg::PROD_W-1:0]         prod_s2;
	logic signed [rpfm_pkg::ESUM_W-1:0]  esum_s2;
	logic                                err_s2, sign_s2;

	logic [rpfm_pkg::IDX_W-1:0]          top_pos;
	logic [rpfm_pkg::PROD_W-1:0]         prod_shr;
	logic [1:0]                          norm_sh;
	logic                                carry_n;
	logic [rpfm_pkg::NORM_W-1:0]         shifted, x_c;
	logic [rpfm_pkg::POS_W-1:0]          clr_pos;
	logic [rpfm_pkg::NORM_W-1:0]         x_s3;
	logic [rpfm_pkg::POS_W-1:0]          cpos_s3;
	logic                                carry_s3;
	logic signed [rpfm_pkg::ESUM_W-1:0]  esum_s3;
	logic                                err_s3, sign_s3;

	logic [rpfm_pkg::POS_W-1:0]          rnd_pos;
	logic [rpfm_pkg::NORM_W-1:0]         x_shr, r_c, r_shr, r_out;
	logic                                rnd_bit, hi;
	logic [rpfm_pkg::MANT_W-1:0]         mres_c;
	logic [rpfm_pkg::MANT_W-1:0]         mres_s4;
	logic [1:0]                          carry_s4;
	logic signed [rpfm_pkg::ESUM_W-1:0]  esum_s4;
	logic                                err_s4, sign_s4;

	logic signed [rpfm_pkg::ESUM_W-1:0]  ex_c;
	logic [rpfm_pkg::EXP_W-1:0]          ex_cl;
	logic                                err_f;
	logic [rpfm_pkg::FP_EXP_W-1:0]       expf;
	logic [rpfm_pkg::SH_W-1:0]           msh;
	logic [rpfm_pkg::FP_MANT_W-1:0]      mfield;
	logic [rpfm_pkg::WORD_W-1:0]         product_c;
	logic [rpfm_pkg::WORD_W-1:0]         product_s5;
	logic                                range_error_s5;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_bits_q  <= rpfm_pkg::EXP_BITS_RST;
			mant_bits_q <= rpfm_pkg::MANT_BITS_RST;
		end else if (wr_en) begin
			unique case (rpfm_pkg::reg_idx_t'(wr_index))
				rpfm_pkg::REG_EXP_BITS: begin
					exp_bits_q <= wr_data;
				end
				rpfm_pkg::REG_MANT_BITS: begin
					mant_bits_q <= wr_data;
				end
			endcase
		end
	end

	assign fmt = rpfm_pkg::make_fmt(exp_bits_q, mant_bits_q);

	// A stage advances when it is empty or the stage after it advances.
	assign adv_s5   = !valid_s5 || !out_stall;
	assign adv_s4   = !valid_s4 || adv_s5;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
			if (adv_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stage 1: narrowing.
	rpfm_narrow u_narrow_a (
		.operand (operand_a),
		.fmt     (fmt),
		.res     (nar_a)
	);

	rpfm_narrow u_narrow_b (
		.operand (operand_b),
		.fmt     (fmt),
		.res     (nar_b)
	);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			na_s1 <= nar_a;
			nb_s1 <= nar_b;
		end
	end

	// Stage 2: significand multiply and exponent sum.
	assign hidden = rpfm_pkg::SIG_W'(1) << fmt.m_w;
	assign sig_a  = {1'b0, na_s1.mant} | hidden;
	assign sig_b  = {1'b0, nb_s1.mant} | hidden;
	assign prod_c = rpfm_pkg::PROD_W'(sig_a) * rpfm_pkg::PROD_W'(sig_b);
	assign esum_c = $signed({3'b000, na_s1.exp}) + $signed({3'b000, nb_s1.exp})
	              - $signed({3'b000, fmt.bias});

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			prod_s2 <= prod_c;
			esum_s2 <= esum_c;
			err_s2  <= na_s1.err | nb_s1.err;
			sign_s2 <= na_s1.sign ^ nb_s1.sign;
		end
	end

	// Stage 3: normalization. With a narrowing error and the top bit set the
	// product stays unshifted and gets no normalization carry.
	assign top_pos  = rpfm_pkg::IDX_W'({fmt.m_w, 1'b1});
	assign prod_shr = prod_s2 >> top_pos;

	always_comb begin
		if (!prod_shr[0]) begin
			norm_sh = 2'd2;
			carry_n = 1'b0;
		end else if (!err_s2) begin
			norm_sh = 2'd1;
			carry_n = 1'b1;
		end else begin
			norm_sh = 2'd0;
			carry_n = 1'b0;
		end
		shifted = rpfm_pkg::NORM_W'(prod_s2) << norm_sh;
		clr_pos = rpfm_pkg::POS_W'(top_pos) + rpfm_pkg::POS_W'(norm_sh);
		x_c     = shifted & ~(rpfm_pkg::NORM_W'(1) << clr_pos);
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			x_s3     <= x_c;
			cpos_s3  <= clr_pos;
			carry_s3 <= carry_n;
			esum_s3  <= esum_s2;
			err_s3   <= err_s2;
			sign_s3  <= sign_s2;
		end
	end

	// Stage 4: round half-up on the guard bit, then renormalize on carry-out.
	assign rnd_pos = rpfm_pkg::POS_W'(fmt.m_w) + rpfm_pkg::POS_W'(1);
	assign x_shr   = x_s3 >> rnd_pos;
	assign rnd_bit = x_shr[0];
	assign r_c     = x_s3 + (rpfm_pkg::NORM_W'(rnd_bit) << rnd_pos);
	assign r_shr   = r_c >> cpos_s3;
	assign hi      = r_shr[0];
	assign r_out   = hi ? (r_c >> rnd_pos) : (r_c >> (rnd_pos + rpfm_pkg::POS_W'(1)));
	assign mres_c  = r_out[rpfm_pkg::MANT_W-1:0] & fmt.mmask;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			mres_s4  <= mres_c;
			carry_s4 <= {1'b0, carry_s3} + {1'b0, hi};
			esum_s4  <= esum_s3;
			err_s4   <= err_s3;
			sign_s4  <= sign_s3;
		end
	end

	// Stage 5: exponent clamp and widening back to single precision.
	assign ex_c = esum_s4 + $signed({{(rpfm_pkg::ESUM_W-2){1'b0}}, carry_s4});

	always_comb begin
		if (ex_c > $signed({3'b000, fmt.emax})) begin
			ex_cl = fmt.emax;
			err_f = 1'b1;
		end else if (ex_c[rpfm_pkg::ESUM_W-1]) begin
			ex_cl = '0;
			err_f = 1'b1;
		end else begin
			ex_cl = ex_c[rpfm_pkg::EXP_W-1:0];
			err_f = err_s4;
		end
		expf   = rpfm_pkg::FP_EXP_W'(ex_cl) - rpfm_pkg::FP_EXP_W'(fmt.bias)
		       + rpfm_pkg::FP_EXP_W'(rpfm_pkg::FP32_BIAS);
		msh    = rpfm_pkg::SH_W'(rpfm_pkg::FP_MANT_W) - rpfm_pkg::SH_W'(fmt.m_w);
		mfield = rpfm_pkg::FP_MANT_W'(mres_s4) << msh;
		if (err_f) begin
			product_c = {1'b0, expf, {rpfm_pkg::FP_MANT_W{1'b0}}};
		end else begin
			product_c = {sign_s4, expf, mfield};
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			product_s5     <= product_c;
			range_error_s5 <= err_f;
		end
	end

	assign out_valid   = valid_s5;
	assign product     = product_s5;
	assign range_error = range_error_s5;

endmodule

### src/rpfm_checker.sv
// ----------------------------------------------------------------------------
// Reduced-precision float multiplier checker
// Port-level properties of the multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`include "reduced_precision_float_multiplier_top_defines.svh"

module rpfm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [rpfm_pkg::WORD_W-1:0]       product,
	input logic                              range_error
);

	// A range error clears the sign and the whole mantissa field.
	`RPFM_ASSERT_SAME(a_err_clears, clk, arst_n, out_valid && range_error, !product[31] && (product[22:0] == 23'd0), "range error result carries sign or mantissa bits")

	// The reduced mantissa never reaches the low byte of the single pattern.
	`RPFM_ASSERT_SAME(a_low_byte_zero, clk, arst_n, out_valid, product[7:0] == 8'd0, "low mantissa bits of result are not zero-filled")

	// With the output stage empty the pipeline must take a request.
	`RPFM_ASSERT_SAME(a_empty_takes, clk, arst_n, !out_valid, !in_stall, "input stalled while the output stage is empty")

	// A stalled result holds.
	`RPFM_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(product) && $stable(range_error), "stalled result changed")

endmodule

bind reduced_precision_float_multiplier_top rpfm_checker u_rpfm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.product     (product),
	.range_error (range_error)
);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reduced-precision float multiplier testbench
// Drives operand pairs through the valid/stall ports under several minifloat
// formats and idle patterns, predicts most products in a behavioral model of
// the narrowing, multiply, rounding and clamping, and compares every result.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT    = 1000;
	localparam int HOLD_CYCLES       = 60;
	localparam int PHASES            = 8;
	localparam int ITEMS_PER_PHASE   = 154;
	localparam int DIRECTED_ROWS     = 23;

	typedef struct packed {
		logic [rpfm_pkg::WORD_W-1:0] product;
		logic                        range_error;
	} product_result_t;

	typedef struct packed {
		logic [rpfm_pkg::CFG_W-1:0]  exp_cfg;
		logic [rpfm_pkg::CFG_W-1:0]  mant_cfg;
		logic [rpfm_pkg::WORD_W-1:0] a;
		logic [rpfm_pkg::WORD_W-1:0] b;
		logic                        typed;
		logic [rpfm_pkg::WORD_W-1:0] product;
		logic                        range_error;
	} directed_row_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           wr_en       = 1'b0;
	logic [rpfm_pkg::CFG_IDX_W-1:0] wr_index    = rpfm_pkg::REG_EXP_BITS;
	logic [rpfm_pkg::CFG_W-1:0]     wr_data     = '0;
	logic                           in_valid    = 1'b0;
	logic                           in_stall;
	logic [rpfm_pkg::WORD_W-1:0]    operand_a   = '0;
	logic [rpfm_pkg::WORD_W-1:0]    operand_b   = '0;
	logic                           out_valid;
	logic                           out_stall   = 1'b0;
	logic [rpfm_pkg::WORD_W-1:0]    product;
	logic                           range_error;

	product_result_t expected_products [$];
	int              mismatch_count = 0;
	logic [rpfm_pkg::CFG_W-1:0] fmt_exp  = rpfm_pkg::EXP_BITS_RST;
	logic [rpfm_pkg::CFG_W-1:0] fmt_mant = rpfm_pkg::MANT_BITS_RST;
	int              idle_pct  = 0;
	int              stall_pct = 0;
	logic            hold_request = 1'b0;
	logic            hold_done    = 1'b0;
	int              hold_left    = 0;
	int              quiet_cycles = 0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{4'd8,  4'd7,  32'h3F800000, 32'h3F800000, 1'b1, 32'h3F800000, 1'b0},
		'{4'd8,  4'd7,  32'h00000000, 32'h3F800000, 1'b1, 32'h00000000, 1'b0},
		'{4'd8,  4'd7,  32'h80000000, 32'h3F800000, 1'b1, 32'h80000000, 1'b0},
		'{4'd8,  4'd7,  32'h7F000000, 32'hFF000000, 1'b1, 32'h7F800000, 1'b1},
		'{4'd8,  4'd7,  32'h00800000, 32'h00800000, 1'b1, 32'h00000000, 1'b1},
		'{4'd8,  4'd7,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
		'{4'd8,  4'd7,  32'h3FFFFFFF, 32'h3FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{4'd8,  4'd7,  32'h40490FDB, 32'hC02DF854, 1'b0, 32'h0, 1'b0},
		'{4'd2,  4'd2,  32'h3F800000, 32'h3F800000, 1'b1, 32'h3F800000, 1'b0},
		'{4'd2,  4'd2,  32'h41000000, 32'h3F800000, 1'b1, 32'h40800000, 1'b1},
		'{4'd2,  4'd2,  32'h41400000, 32'h3FC00000, 1'b0, 32'h0, 1'b0},
		'{4'd2,  4'd2,  32'h3E800000, 32'h3F800000, 1'b0, 32'h0, 1'b0},
		'{4'd2,  4'd2,  32'h3FF00000, 32'h3FF00000, 1'b0, 32'h0, 1'b0},
		'{4'd15, 4'd15, 32'h3FFFFFFF, 32'h3FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{4'd15, 4'd15, 32'h3F800001, 32'h3F800000, 1'b0, 32'h0, 1'b0},
		'{4'd15, 4'd15, 32'h7F7FFFFF, 32'h3F800000, 1'b0, 32'h0, 1'b0},
		'{4'd0,  4'd0,  32'h3F800000, 32'h3F800000, 1'b1, 32'h3F800000, 1'b0},
		'{4'd0,  4'd0,  32'hC0400000, 32'h40400000, 1'b0, 32'h0, 1'b0},
		'{4'd1,  4'd1,  32'h7FFFFFFF, 32'h00000000, 1'b0, 32'h0, 1'b0},
		'{4'd9,  4'd14, 32'h3FAAAAAA, 32'h3FD55555, 1'b0, 32'h0, 1'b0},
		'{4'd9,  4'd14, 32'hFF7FFFFF, 32'h7F7FFFFF, 1'b0, 32'h0, 1'b0},
		'{4'd5,  4'd10, 32'h47000000, 32'h3F800000, 1'b0, 32'h0, 1'b0},
		'{4'd5,  4'd10, 32'h38000000, 32'h38000000, 1'b0, 32'h0, 1'b0}
	};

	reduced_precision_float_multiplier_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.product     (product),
		.range_error (range_error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned effective_width(input logic [rpfm_pkg::CFG_W-1:0] cfg,
			input int hi);
		if (cfg < rpfm_pkg::MIN_WIDTH) begin
			return rpfm_pkg::MIN_WIDTH;
		end else if (int'(cfg) > hi) begin
			return hi;
		end
		return cfg;
	endfunction

	function automatic int clamp_exponent(input int e, input int emax, inout bit err);
		if (e > emax) begin
			err = 1'b1;
			return emax;
		end else if (e < 0) begin
			err = 1'b1;
			return 0;
		end
		return e;
	endfunction

	function automatic product_result_t predict_product(input logic [rpfm_pkg::WORD_W-1:0] a,
			input logic [rpfm_pkg::WORD_W-1:0] b, input logic [rpfm_pkg::CFG_W-1:0] exp_cfg,
			input logic [rpfm_pkg::CFG_W-1:0] mant_cfg);
		int unsigned     ew;
		int unsigned     mw;
		int unsigned     shift;
		int              bias;
		int              emax;
		int              ea;
		int              eb;
		int              ex;
		int              carry;
		bit              err;
		bit              sres;
		bit [31:0]       mmask;
		bit [31:0]       ma;
		bit [31:0]       mb;
		bit [31:0]       mres;
		bit [63:0]       sig_prod;
		product_result_t res;
		ew    = effective_width(exp_cfg, rpfm_pkg::MAX_EXP_BITS);
		mw    = effective_width(mant_cfg, rpfm_pkg::MAX_MANT_BITS);
		bias  = (1 << (ew - 1)) - 1;
		emax  = (1 << ew) - 1;
		mmask = (32'd1 << mw) - 1;
		err   = 1'b0;
		carry = 0;
		ea = clamp_exponent(int'(a[30:23]) - rpfm_pkg::FP32_BIAS + bias, emax, err);
		eb = clamp_exponent(int'(b[30:23]) - rpfm_pkg::FP32_BIAS + bias, emax, err);
		ma = (32'(a) >> (rpfm_pkg::FP_MANT_W - mw)) & mmask;
		mb = (32'(b) >> (rpfm_pkg::FP_MANT_W - mw)) & mmask;
		sig_prod = 64'(ma | (32'd1 << mw)) * 64'(mb | (32'd1 << mw));
		// With a range error already raised, a product of two or more stays unshifted.
		if (!sig_prod[2 * mw + 1]) begin
			sig_prod = sig_prod << 2;
			shift    = 2;
		end else if (!err) begin
			sig_prod = sig_prod << 1;
			carry    = 1;
			shift    = 1;
		end else begin
			shift = 0;
		end
		sig_prod[2 * mw + 1 + shift] = 1'b0;
		if (sig_prod[mw + 1]) begin
			sig_prod = sig_prod + (64'd1 << (mw + 1));
		end
		if (sig_prod[2 * mw + 1 + shift]) begin
			sig_prod = sig_prod << 1;
			carry    = carry + 1;
		end
		mres = 32'(sig_prod >> (mw + 2)) & mmask;
		ex   = clamp_exponent(ea + eb - bias + carry, emax, err);
		sres = a[31] ^ b[31];
		if (err) begin
			sres = 1'b0;
			mres = '0;
		end
		res.product     = {sres, 31'd0}
			| (32'((ex - bias + rpfm_pkg::FP32_BIAS) & 8'hFF) << rpfm_pkg::FP_MANT_W)
			| (mres << (rpfm_pkg::FP_MANT_W - mw));
		res.range_error = err;
		return res;
	endfunction

	function automatic logic [rpfm_pkg::WORD_W-1:0] random_operand(
			input logic [rpfm_pkg::CFG_W-1:0] exp_cfg);
		int unsigned span;
		int          field;
		logic [22:0] frac;
		span  = 1 << (effective_width(exp_cfg, rpfm_pkg::MAX_EXP_BITS) - 1);
		field = rpfm_pkg::FP32_BIAS - int'(span) - 1 + int'($urandom_range(2 * span + 2));
		if (field < 0) begin
			field = 0;
		end else if (field > 255) begin
			field = 255;
		end
		case ($urandom_range(3))
			0: frac = '1;
			1: frac = '0;
			default: frac = 23'($urandom());
		endcase
		if ($urandom_range(4) == 0) begin
			return $urandom();
		end
		return {1'($urandom()), 8'(field), frac};
	endfunction

	task automatic report_mismatch(input string what, input logic [rpfm_pkg::WORD_W-1:0] got,
			input logic [rpfm_pkg::WORD_W-1:0] want);
		$display("Mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
		mismatch_count++;
	endtask

	task automatic send_request(input logic [rpfm_pkg::WORD_W-1:0] a,
			input logic [rpfm_pkg::WORD_W-1:0] b,
			input logic typed, input product_result_t typed_result);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (typed) begin
			expected_products.push_back(typed_result);
		end else begin
			expected_products.push_back(predict_product(a, b, fmt_exp, fmt_mant));
		end
	endtask

	task automatic wait_products_drained();
		in_valid <= 1'b0;
		while (expected_products.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic set_format(input logic [rpfm_pkg::CFG_W-1:0] exp_cfg,
			input logic [rpfm_pkg::CFG_W-1:0] mant_cfg);
		wr_en    <= 1'b1;
		wr_index <= rpfm_pkg::REG_EXP_BITS;
		wr_data  <= exp_cfg;
		@(posedge clk);
		wr_index <= rpfm_pkg::REG_MANT_BITS;
		wr_data  <= mant_cfg;
		@(posedge clk);
		wr_en    <= 1'b0;
		fmt_exp  = exp_cfg;
		fmt_mant = mant_cfg;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_request && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_products
		product_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_products.size() == 0) begin
				report_mismatch("product with no request outstanding", product, '0);
			end else begin
				want = expected_products.pop_front();
				if (product !== want.product) begin
					report_mismatch("product", product, want.product);
				end
				if (range_error !== want.range_error) begin
					report_mismatch("range_error", 32'(range_error), 32'(want.range_error));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d cycles without a transfer", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int                         phase;
		int                         row;
		logic [rpfm_pkg::CFG_W-1:0] exp_cfg;
		logic [rpfm_pkg::CFG_W-1:0] mant_cfg;
		product_result_t            typed_result;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (directed_rows[row].exp_cfg != fmt_exp
					|| directed_rows[row].mant_cfg != fmt_mant) begin
				wait_products_drained();
				set_format(directed_rows[row].exp_cfg, directed_rows[row].mant_cfg);
			end
			typed_result.product     = directed_rows[row].product;
			typed_result.range_error = directed_rows[row].range_error;
			send_request(directed_rows[row].a, directed_rows[row].b, directed_rows[row].typed,
				typed_result);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			wait_products_drained();
			case (phase)
				0: begin
					exp_cfg  = 4'd2;
					mant_cfg = 4'd2;
				end
				1: begin
					exp_cfg  = 4'd8;
					mant_cfg = 4'd15;
				end
				2: begin
					exp_cfg  = 4'd15;
					mant_cfg = 4'd0;
				end
				3: begin
					exp_cfg  = 4'd0;
					mant_cfg = 4'd15;
				end
				default: begin
					exp_cfg  = 4'($urandom_range(15));
					mant_cfg = 4'($urandom_range(15));
				end
			endcase
			set_format(exp_cfg, mant_cfg);
			case (phase % 4)
				0: begin
					idle_pct  = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct  = 79;
					stall_pct <= 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct <= 79;
				end
				default: begin
					idle_pct  = 31;
					stall_pct <= 31;
				end
			endcase
			// The first phase opens with a long receiver hold-off so that the pipeline fills.
			if (phase == 0) begin
				hold_request <= 1'b1;
			end
			repeat (ITEMS_PER_PHASE) begin
				send_request(random_operand(fmt_exp), random_operand(fmt_exp), 1'b0, '0);
			end
		end

		wait_products_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/rpfm_pkg.sv
src/rpfm_narrow.sv
src/reduced_precision_float_multiplier_top.sv
src/rpfm_checker.sv
verif/tb.sv
